@@ rtl/tpsw_pkg.sv @@
// Package for the TLV property stream walker: beat types, phase/role/cause codes.
// Used by every module under rtl/.
package tpsw_pkg;

    localparam int LenBits = 32;   // width of the body byte counter, 8..32
    localparam int HdrBytes = 8;
    localparam int SizeSelf = 4;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HEADER    = 3'd1,
        PH_PAYLOAD   = 3'd2,
        PH_END_NAME  = 3'd3,
        PH_END_SHORT = 3'd4,
        PH_END_SMALL = 3'd5,
        PH_END_OVER  = 3'd6
    } phase_t;

    typedef enum logic [2:0] {
        ROLE_LEAD     = 3'd0,
        ROLE_HDR      = 3'd1,
        ROLE_HDR_DONE = 3'd2,
        ROLE_PAYLOAD  = 3'd3,
        ROLE_ENDED    = 3'd4,
        ROLE_IGNORED  = 3'd5
    } role_t;

    typedef enum logic [2:0] {
        CAUSE_NONE       = 3'd0,
        CAUSE_ZERO_NAME  = 3'd1,
        CAUSE_SHORT_TAIL = 3'd2,
        CAUSE_SMALL_SIZE = 3'd3,
        CAUSE_OVERRUN    = 3'd4
    } cause_t;

    typedef struct packed {
        logic        start_req;
        logic [7:0]  data_byte;
        logic [31:0] body_length;
    } in_beat_t;

    typedef struct packed {
        logic [2:0]  role;
        logic [2:0]  end_cause;
        logic [15:0] name_index;
        logic [15:0] type_index;
        logic [31:0] payload_size;
        logic [7:0]  payload_byte;
        logic [31:0] payload_offset;
        logic        payload_last;
        logic [15:0] property_count;
    } out_beat_t;

endpackage

@@ rtl/tlv_property_stream_walker_top.sv @@
// TLV property stream walker: top level with input register, walker and result register.
// Depends on tpsw_pkg, tpsw_in_stage, tpsw_walker, tpsw_out_stage.
//
// Usage: one struct body enters as a byte stream on the src channel, one byte per beat.
// The beat with start_req set carries the leading byte and body_length; it restarts
// the walk at any point. Every input beat yields exactly one result beat on the dst
// channel, carrying the byte's role, end cause, current header fields, payload
// position and the count of accepted properties.
// Path: each byte passes the input register and then the result register before its
// result shows on dst_valid; a stall on dst can hold it in either register.
// Throughput: one byte per clock while dst_stall is low; the walk state updates as a
// byte moves from the input register to the result register.
// Reset: clears both stage valids and returns the walk to idle; bytes seen before
// any start beat report role ignored.
// Stall: while dst_stall holds, the result register keeps its beat; the input
// register absorbs one more byte, then src_stall rises until the result leaves.
module tlv_property_stream_walker_top (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    output logic                src_stall,
    input  tpsw_pkg::in_beat_t  src_beat,
    output logic                dst_valid,
    input  logic                dst_stall,
    output tpsw_pkg::out_beat_t dst_beat
);
    import tpsw_pkg::*;

    logic      item_valid;
    in_beat_t  item;
    logic      out_ready;
    logic      fire;
    out_beat_t result;

    assign fire = item_valid && out_ready;

    tpsw_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .src_valid  (src_valid),
        .src_stall  (src_stall),
        .src_beat   (src_beat),
        .advance    (out_ready),
        .item_valid (item_valid),
        .item       (item)
    );

    tpsw_walker u_walker (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .item   (item),
        .result (result)
    );

    tpsw_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire),
        .result    (result),
        .ready     (out_ready),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_beat  (dst_beat)
    );

`ifndef NO_ASSERTIONS
    // input only backs up when both registers hold beats and the output is stalled
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        src_stall |-> (item_valid && dst_valid && dst_stall))
        else $error("src_stall raised with room in the pipeline");

    // a byte leaving the input register always lands in the result register
    a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> dst_valid)
        else $error("decoded beat lost on its way to the result register");

    a_last_is_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_beat.payload_last) |-> (dst_beat.role == ROLE_PAYLOAD))
        else $error("payload_last on a non-payload beat");

    a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (dst_valid && dst_beat.role == ROLE_IGNORED) |->
        (dst_beat.property_count == 16'd0 && dst_beat.end_cause == CAUSE_NONE))
        else $error("ignored beat carries walk state");
`endif
endmodule

@@ rtl/tpsw_in_stage.sv @@
// Input register stage of the TLV property stream walker.
// Depends on tpsw_pkg.
module tpsw_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              src_valid,
    output logic              src_stall,
    input  tpsw_pkg::in_beat_t src_beat,
    input  logic              advance,
    output logic              item_valid,
    output tpsw_pkg::in_beat_t item
);
    import tpsw_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_beat_t item_reg;
    logic     accept;

    assign src_stall  = valid_reg && !advance;
    assign accept     = src_valid && !src_stall;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= src_beat;
        end
    end
endmodule

@@ rtl/tpsw_walker.sv @@
// Walk state and per-byte decode of the TLV property stream walker.
// Depends on tpsw_pkg.
module tpsw_walker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  tpsw_pkg::in_beat_t item,
    output tpsw_pkg::out_beat_t result
);
    import tpsw_pkg::*;

    phase_t              phase_reg, phase_next;
    logic [2:0]          hpos_reg, hpos_next;
    logic [15:0]         name_reg, name_next;
    logic [15:0]         type_reg, type_next;
    logic [31:0]         size_reg, size_next;
    logic [LenBits-1:0]  rem_reg, rem_next;
    logic [31:0]         pcnt_reg, pcnt_next;
    logic [15:0]         count_reg, count_next;

    logic [LenBits-1:0]  blen;
    logic [LenBits-1:0]  rem_dec;
    logic [LenBits-1:0]  rem_lead;
    logic [31:0]         psize;
    logic [31:0]         new_psize;
    logic                lead_short;
    logic                tail_short;
    role_t               role;
    logic [7:0]          pbyte;
    logic [31:0]         poff;
    logic                plast;
    logic [2:0]          cause;
    logic [7:0]          b;

    assign b        = item.data_byte;
    assign blen     = item.body_length[LenBits-1:0];
    assign rem_dec  = rem_reg - LenBits'(1);
    // the lead byte counts toward the length but is not parsed
    assign rem_lead = (blen == '0) ? '0 : blen - LenBits'(1);
    assign psize    = size_reg - 32'(SizeSelf);
    // payload length of the header being closed on its eighth byte
    assign new_psize = {b, size_reg[23:0]} - 32'(SizeSelf);
    // short-tail test wherever a header would begin, on the updated count
    assign lead_short = (rem_lead < LenBits'(HdrBytes));
    assign tail_short = (rem_dec < LenBits'(HdrBytes));

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        name_next  = name_reg;
        type_next  = type_reg;
        size_next  = size_reg;
        rem_next   = rem_reg;
        pcnt_next  = pcnt_reg;
        count_next = count_reg;
        role       = ROLE_ENDED;
        pbyte      = 8'd0;
        poff       = 32'd0;
        plast      = 1'b0;

        if (item.start_req)
        begin
            name_next  = 16'd0;
            type_next  = 16'd0;
            size_next  = 32'd0;
            pcnt_next  = 32'd0;
            count_next = 16'd0;
            rem_next   = rem_lead;
            role       = ROLE_LEAD;
            hpos_next  = 3'd0;
            phase_next = lead_short ? PH_END_SHORT : PH_HEADER;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    role = ROLE_IGNORED;
                end
                PH_HEADER:
                begin
                    rem_next  = rem_dec;
                    role      = ROLE_HDR;
                    hpos_next = hpos_reg + 3'd1;
                    case (hpos_reg)
                        3'd0:    name_next = {8'd0, b};
                        3'd1:    name_next = {b, name_reg[7:0]};
                        3'd2:    type_next = {8'd0, b};
                        3'd3:    type_next = {b, type_reg[7:0]};
                        3'd4:    size_next = {24'd0, b};
                        3'd5:    size_next = {16'd0, b, size_reg[7:0]};
                        3'd6:    size_next = {8'd0, b, size_reg[15:0]};
                        default: size_next = {b, size_reg[23:0]};
                    endcase
                    if (hpos_reg == 3'd1 && name_next == 16'd0)
                    begin
                        phase_next = PH_END_NAME;
                        role       = ROLE_ENDED;
                    end
                    else if (hpos_reg == 3'd7)
                    begin
                        if (size_next < 32'(SizeSelf))
                        begin
                            phase_next = PH_END_SMALL;
                            role       = ROLE_ENDED;
                        end
                        else if (new_psize > 32'(rem_dec))
                        begin
                            phase_next = PH_END_OVER;
                            role       = ROLE_ENDED;
                        end
                        else
                        begin
                            role = ROLE_HDR_DONE;
                            if (count_reg != 16'hFFFF)
                            begin
                                count_next = count_reg + 16'd1;
                            end
                            pcnt_next = 32'd0;
                            if (new_psize == 32'd0)
                            begin
                                hpos_next  = 3'd0;
                                phase_next = tail_short ? PH_END_SHORT : PH_HEADER;
                            end
                            else
                            begin
                                phase_next = PH_PAYLOAD;
                            end
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    role      = ROLE_PAYLOAD;
                    pbyte     = b;
                    poff      = pcnt_reg;
                    rem_next  = rem_dec;
                    pcnt_next = pcnt_reg + 32'd1;
                    if (pcnt_next >= psize)
                    begin
                        plast      = 1'b1;
                        hpos_next  = 3'd0;
                        phase_next = tail_short ? PH_END_SHORT : PH_HEADER;
                    end
                end
                default:
                begin
                    role = ROLE_ENDED;
                end
            endcase
        end
    end

    always_comb
    begin
        case (phase_next)
            PH_END_NAME:  cause = CAUSE_ZERO_NAME;
            PH_END_SHORT: cause = CAUSE_SHORT_TAIL;
            PH_END_SMALL: cause = CAUSE_SMALL_SIZE;
            PH_END_OVER:  cause = CAUSE_OVERRUN;
            default:      cause = CAUSE_NONE;
        endcase
    end

    always_comb
    begin
        result.role           = role;
        result.end_cause      = cause;
        result.name_index     = name_next;
        result.type_index     = type_next;
        result.payload_size   = (size_next >= 32'(SizeSelf)) ?
                                size_next - 32'(SizeSelf) : 32'd0;
        result.payload_byte   = pbyte;
        result.payload_offset = poff;
        result.payload_last   = plast;
        result.property_count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            hpos_reg  <= 3'd0;
            name_reg  <= 16'd0;
            type_reg  <= 16'd0;
            size_reg  <= 32'd0;
            rem_reg   <= '0;
            pcnt_reg  <= 32'd0;
            count_reg <= 16'd0;
        end
        else if (fire)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            name_reg  <= name_next;
            type_reg  <= type_next;
            size_reg  <= size_next;
            rem_reg   <= rem_next;
            pcnt_reg  <= pcnt_next;
            count_reg <= count_next;
        end
    end
endmodule

@@ rtl/tpsw_out_stage.sv @@
// Result register stage of the TLV property stream walker.
// Depends on tpsw_pkg.
module tpsw_out_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tpsw_pkg::out_beat_t result,
    output logic                ready,
    output logic                dst_valid,
    input  logic                dst_stall,
    output tpsw_pkg::out_beat_t dst_beat
);
    import tpsw_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    out_beat_t beat_reg;

    // room when empty or when the held beat leaves this cycle
    assign ready     = !valid_reg || !dst_stall;
    assign dst_valid = valid_reg;
    assign dst_beat  = beat_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!dst_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg <= result;
        end
    end
endmodule

@@ tb/tpsw_walk_check.sv @@
// Walk checker for the TLV property stream walker: follows both channels, works out
// each result beat from the accepted input beats and compares it with the delivered one.
// Depends on tpsw_pkg.
module tpsw_walk_check (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                src_valid,
    input  logic                src_stall,
    input  tpsw_pkg::in_beat_t  src_beat,
    input  logic                dst_valid,
    input  logic                dst_stall,
    input  tpsw_pkg::out_beat_t dst_beat,
    output int                  fail_count,
    output int                  due_count,
    output int                  checked_count,
    output logic [5:0]          roles_seen,
    output logic [4:0]          causes_seen
);
    import tpsw_pkg::*;

    // walk state, kept apart from the block
    phase_t             walk_phase;
    logic [2:0]         hdr_pos;
    logic [15:0]        name_q;
    logic [15:0]        type_q;
    logic [31:0]        size_q;
    logic [31:0]        pay_cnt;
    logic [LenBits-1:0] remain_q;
    logic [15:0]        prop_cnt;

    out_beat_t walk_results_due[$];
    int        n_fail;
    int        n_checked;

    function automatic void open_header();
        hdr_pos = '0;
        if (remain_q < LenBits'(HdrBytes))
            walk_phase = PH_END_SHORT;
        else
            walk_phase = PH_HEADER;
    endfunction

    function automatic out_beat_t walk_one_byte(input in_beat_t b);
        out_beat_t   r;
        role_t       role;
        logic [2:0]  pos;
        logic [31:0] psize;
        r = '0;
        if (b.start_req)
        begin
            name_q   = '0;
            type_q   = '0;
            size_q   = '0;
            pay_cnt  = '0;
            prop_cnt = '0;
            remain_q = b.body_length[LenBits-1:0];
            // the lead byte counts toward the length but is not parsed
            if (remain_q != '0)
                remain_q = remain_q - LenBits'(1);
            role = ROLE_LEAD;
            open_header();
        end
        else
        begin
            case (walk_phase)
                PH_IDLE: role = ROLE_IGNORED;
                PH_HEADER:
                begin
                    pos = hdr_pos;
                    hdr_pos = pos + 3'd1;
                    remain_q = remain_q - LenBits'(1);
                    role = ROLE_HDR;
                    case (pos)
                        3'd0: name_q = {8'h00, b.data_byte};
                        3'd1: name_q = name_q | {b.data_byte, 8'h00};
                        3'd2: type_q = {8'h00, b.data_byte};
                        3'd3: type_q = type_q | {b.data_byte, 8'h00};
                        3'd4: size_q = {24'h000000, b.data_byte};
                        default:
                            size_q = size_q | ({24'h000000, b.data_byte} << (8 * (pos - 4)));
                    endcase
                    if (pos == 3'd1 && name_q == '0)
                    begin
                        walk_phase = PH_END_NAME;
                        role = ROLE_ENDED;
                    end
                    else if (pos == 3'd7)
                    begin
                        if (size_q < 32'(SizeSelf))
                        begin
                            walk_phase = PH_END_SMALL;
                            role = ROLE_ENDED;
                        end
                        else if ((size_q - 32'(SizeSelf)) > 32'(remain_q))
                        begin
                            walk_phase = PH_END_OVER;
                            role = ROLE_ENDED;
                        end
                        else
                        begin
                            role = ROLE_HDR_DONE;
                            if (prop_cnt != 16'hFFFF)
                                prop_cnt = prop_cnt + 16'd1;
                            pay_cnt = '0;
                            if (size_q == 32'(SizeSelf))
                                open_header();
                            else
                                walk_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    psize = size_q - 32'(SizeSelf);
                    role = ROLE_PAYLOAD;
                    r.payload_byte = b.data_byte;
                    r.payload_offset = pay_cnt;
                    remain_q = remain_q - LenBits'(1);
                    pay_cnt = pay_cnt + 32'd1;
                    if (pay_cnt >= psize)
                    begin
                        r.payload_last = 1'b1;
                        open_header();
                    end
                end
                default: role = ROLE_ENDED;
            endcase
        end

        r.role = role;
        case (walk_phase)
            PH_END_NAME:  r.end_cause = CAUSE_ZERO_NAME;
            PH_END_SHORT: r.end_cause = CAUSE_SHORT_TAIL;
            PH_END_SMALL: r.end_cause = CAUSE_SMALL_SIZE;
            PH_END_OVER:  r.end_cause = CAUSE_OVERRUN;
            default:      r.end_cause = CAUSE_NONE;
        endcase
        r.name_index = name_q;
        r.type_index = type_q;
        r.payload_size = (size_q >= 32'(SizeSelf)) ? size_q - 32'(SizeSelf) : '0;
        r.property_count = prop_cnt;
        return r;
    endfunction

    function automatic string beat_text(input out_beat_t b);
        return $sformatf({"role %0d cause %0d name %h type %h size %h byte %h off %h",
                          " last %b cnt %0d"},
                         b.role, b.end_cause, b.name_index, b.type_index, b.payload_size,
                         b.payload_byte, b.payload_offset, b.payload_last, b.property_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_beat_t want;
        if (!rst_n)
        begin
            walk_phase = PH_IDLE;
            hdr_pos    = '0;
            name_q     = '0;
            type_q     = '0;
            size_q     = '0;
            pay_cnt    = '0;
            remain_q   = '0;
            prop_cnt   = '0;
            walk_results_due.delete();
            n_fail     = 0;
            n_checked  = 0;
            fail_count    <= 0;
            due_count     <= 0;
            checked_count <= 0;
            roles_seen    <= '0;
            causes_seen   <= '0;
        end
        else
        begin
            // result side first: a beat accepted on this edge cannot come out on it
            if (dst_valid && !dst_stall)
            begin
                roles_seen[dst_beat.role] <= 1'b1;
                causes_seen[dst_beat.end_cause] <= 1'b1;
                if (walk_results_due.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= 10)
                        $display("result beat with nothing due: %s", beat_text(dst_beat));
                end
                else
                begin
                    want = walk_results_due.pop_front();
                    n_checked++;
                    if (dst_beat.role !== want.role || dst_beat.end_cause !== want.end_cause
                        || dst_beat.name_index !== want.name_index
                        || dst_beat.type_index !== want.type_index
                        || dst_beat.payload_size !== want.payload_size
                        || dst_beat.payload_byte !== want.payload_byte
                        || dst_beat.payload_offset !== want.payload_offset
                        || dst_beat.payload_last !== want.payload_last
                        || dst_beat.property_count !== want.property_count)
                    begin
                        n_fail++;
                        if (n_fail <= 10)
                        begin
                            $display("mismatch on result %0d: want %s", n_checked,
                                     beat_text(want));
                            $display("                     got  %s", beat_text(dst_beat));
                        end
                    end
                end
            end
            if (src_valid && !src_stall)
                walk_results_due = {walk_results_due, walk_one_byte(src_beat)};
            fail_count    <= n_fail;
            due_count     <= walk_results_due.size();
            checked_count <= n_checked;
        end
    end

endmodule

@@ tb/tlv_property_stream_walker_top_tb.sv @@
// Top of the TLV property stream walker bench: clock, reset, byte stimulus and verdict.
// Depends on tpsw_pkg, tlv_property_stream_walker_top and tpsw_walk_check.
module tlv_property_stream_walker_top_tb;
    import tpsw_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      src_valid;
    logic      src_stall;
    in_beat_t  src_beat;
    logic      dst_valid;
    logic      dst_stall;
    out_beat_t dst_beat;

    int         fail_count;
    int         due_count;
    int         checked_count;
    logic [5:0] roles_seen;
    logic [4:0] causes_seen;

    int src_idle_pct  = 0;
    int dst_stall_pct = 0;
    int beats_sent    = 0;
    bit pressure_req  = 1'b0;
    bit pressure_done = 1'b0;
    int hold_left     = 0;
    int quiet_cycles  = 0;

    tlv_property_stream_walker_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_beat  (src_beat),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_beat  (dst_beat)
    );

    tpsw_walk_check u_walk_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .src_valid     (src_valid),
        .src_stall     (src_stall),
        .src_beat      (src_beat),
        .dst_valid     (dst_valid),
        .dst_stall     (dst_stall),
        .dst_beat      (dst_beat),
        .fail_count    (fail_count),
        .due_count     (due_count),
        .checked_count (checked_count),
        .roles_seen    (roles_seen),
        .causes_seen   (causes_seen)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // offers one beat from a falling edge and returns at the falling edge after acceptance
    task automatic send_beat(input logic start, input logic [7:0] data, input logic [31:0] len);
        in_beat_t b;
        b.start_req   = start;
        b.data_byte   = data;
        b.body_length = len;
        while ($urandom_range(99) < src_idle_pct)
        begin
            src_valid <= 1'b0;
            @(negedge clk);
        end
        src_valid <= 1'b1;
        src_beat  <= b;
        @(posedge clk);
        while (src_stall)
            @(posedge clk);
        beats_sent++;
        @(negedge clk);
    endtask

    task automatic send_header(input logic [15:0] nm, input logic [15:0] ty,
                               input logic [31:0] size);
        send_beat(1'b0, nm[7:0], $urandom);
        send_beat(1'b0, nm[15:8], $urandom);
        send_beat(1'b0, ty[7:0], $urandom);
        send_beat(1'b0, ty[15:8], $urandom);
        send_beat(1'b0, size[7:0], $urandom);
        send_beat(1'b0, size[15:8], $urandom);
        send_beat(1'b0, size[23:16], $urandom);
        send_beat(1'b0, size[31:24], $urandom);
    endtask

    // One body: mostly well-formed properties with random content, sometimes one bad
    // header, a wrong length, a cut-off restart or plain noise.
    task automatic send_random_body();
        logic [7:0]  body[$];
        logic [15:0] nm;
        logic [15:0] ty;
        logic [31:0] size;
        logic [31:0] blen;
        int          flaw;
        int          n_props;
        int          bad_at;
        int          plen;
        int          n_send;
        int          n_after;
        int          k;
        bit          one_short;
        flaw = $urandom_range(9);   // 0..5 clean, 6 zero name, 7 small size, 8 overrun, 9 noise
        n_props = $urandom_range(1, 4);
        bad_at = $urandom_range(n_props - 1);
        one_short = 1'b0;
        if (flaw == 9)
        begin
            blen = $urandom_range(1) ? $urandom : $urandom_range(40);
            repeat ($urandom_range(4, 30))
                body = {body, 8'($urandom)};
        end
        else
        begin
            for (k = 0; k < n_props; k++)
            begin
                plen = ($urandom_range(7) == 0) ? $urandom_range(24) : $urandom_range(4);
                case ($urandom_range(5))
                    0: nm = 16'hFFFF;
                    1: nm = 16'h0100;
                    default: nm = 16'($urandom_range(1, 65535));
                endcase
                ty = 16'($urandom);
                size = 32'(plen + 4);
                if (k == bad_at)
                begin
                    case (flaw)
                        6: nm = '0;
                        7: size = $urandom_range(3);
                        8:
                        begin
                            if ($urandom_range(1))
                                size = $urandom | 32'h8000_0000;
                            else
                                one_short = 1'b1;
                        end
                        default: ;
                    endcase
                end
                body = {body, nm[7:0], nm[15:8], ty[7:0], ty[15:8],
                        size[7:0], size[15:8], size[23:16], size[31:24]};
                repeat (plen)
                    body = {body, 8'($urandom)};
            end
            // junk tail too short for a header
            if ($urandom_range(1))
                repeat ($urandom_range(1, 7))
                    body = {body, 8'($urandom)};
            blen = body.size() + 1;
            // length one short: the body length leaves out its last byte
            if (one_short)
                blen = blen - 1;
            case ($urandom_range(9))
                0: blen = blen + $urandom_range(1, 40);
                1: blen = $urandom | 32'h8000_0000;
                default: ;
            endcase
        end
        n_send = body.size();
        if ($urandom_range(9) == 0)
            n_send = $urandom_range(body.size());
        n_after = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
        send_beat(1'b1, 8'($urandom), blen);
        for (k = 0; k < n_send; k++)
            send_beat(1'b0, body[k], $urandom);
        repeat (n_after)
            send_beat(1'b0, 8'($urandom), $urandom);
    endtask

    // receiver: random stall, plus one long hold-off so the block backs up
    initial
    begin
        dst_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pressure_req && !pressure_done)
            begin
                hold_left = 300;
                pressure_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                dst_stall <= 1'b1;
            end
            else
            begin
                dst_stall <= ($urandom_range(99) < dst_stall_pct);
            end
        end
    end

    // no beat accepted on either side for this long means the block hung;
    // the longest legal quiet stretch is the receiver's long hold-off
    always @(posedge clk)
    begin
        if (!rst_n || (src_valid && !src_stall) || (dst_valid && !dst_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= 4000)
        begin
            $display("[tlv_property_stream_walker_top] ERROR");
            $finish;
        end
    end

    initial
    begin
        int ph;
        int phase_start;
        rst_n     = 1'b0;
        src_valid = 1'b0;
        src_beat  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // bytes before any start are ignored
        send_beat(1'b0, 8'h00, 32'h0000_0000);
        send_beat(1'b0, 8'hFF, 32'hFFFF_FFFF);
        // empty body ends at once; the next byte is past the end
        send_beat(1'b1, 8'hFF, 32'h0000_0000);
        send_beat(1'b0, 8'h00, 32'h0000_0000);
        // longest body, zero name seen on the second header byte
        send_beat(1'b1, 8'h00, 32'hFFFF_FFFF);
        send_beat(1'b0, 8'h00, 32'h0000_0000);
        send_beat(1'b0, 8'h00, 32'h0000_0000);
        // empty payload, body used up right at header done
        send_beat(1'b1, 8'hA5, 32'd9);
        send_header(16'hFFFF, 16'hFFFF, 32'd4);
        // restart mid-header, then a size far past the body
        send_beat(1'b1, 8'h5A, 32'd9);
        send_beat(1'b0, 8'h01, 32'h0000_0000);
        send_beat(1'b1, 8'h00, 32'd12);
        send_header(16'h0100, 16'h8000, 32'hFFFF_FFFF);

        for (ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    src_idle_pct  = 0;
                    dst_stall_pct = 0;
                end
                1:
                begin
                    src_idle_pct  = 53;
                    dst_stall_pct = 0;
                end
                2:
                begin
                    src_idle_pct  = 0;
                    dst_stall_pct = 53;
                end
                default:
                begin
                    src_idle_pct  = 37;
                    dst_stall_pct = 37;
                end
            endcase
            if (ph == 0)
                pressure_req = 1'b1;
            phase_start = beats_sent;
            while (beats_sent - phase_start < 200)
                send_random_body();
        end
        src_valid <= 1'b0;

        while (due_count != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("walker run: %0d input beats, directed corner bodies then four stall mixes",
                 beats_sent);
        $display("  %0d results compared; roles seen %b, end causes seen %b",
                 checked_count, roles_seen, causes_seen);
        if (fail_count == 0)
            $display("[tlv_property_stream_walker_top] OK");
        else
            $display("[tlv_property_stream_walker_top] ERROR");
        $finish;
    end

endmodule
